FILE: hw/rtl/stac_pkg.sv
// Shared types and constants for the segment table allocate/check block.
// Holds the request codes, the token that walks the cell chain and the
// stored segment entry. No dependencies.
`default_nettype none

package stac_pkg;

    localparam int DATA_W        = 24;
    localparam int ADDR_W        = DATA_W + 1;
    localparam int NEED_W        = DATA_W + 2;
    localparam int FUNC_W        = 2;
    localparam int USED_W        = 5;
    localparam int SLOTS_DEFAULT = 16;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACCESS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Request plus the results gathered so far as it passes the cells.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] base;
        logic [ADDR_W-1:0] end_addr;
        logic [DATA_W-1:0] lim;
        logic              zero;
        logic              overlap;
        logic [ADDR_W-1:0] top;
        logic              hit;
    } stac_token_t;

    typedef struct packed {
        logic [DATA_W-1:0] lbase;
        logic [DATA_W-1:0] lim;
        logic [DATA_W-1:0] pbase;
    } stac_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stac_req_if.sv
// Request channel of the segment table block: valid/ready plus payload.
// Depends on stac_pkg for the field widths.
`default_nettype none

interface stac_req_if;
    import stac_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] log_base;
    logic [DATA_W-1:0] req_size;

    modport source (output valid, func, log_base, req_size, input ready);
    modport sink   (input valid, func, log_base, req_size, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/stac_rsp_if.sv
// Response channel of the segment table block: valid/ready plus payload.
// Depends on stac_pkg for the field widths.
`default_nettype none

interface stac_rsp_if;
    import stac_pkg::*;

    logic              valid;
    logic              ready;
    logic              fault;
    logic [DATA_W-1:0] phys_base;
    logic [USED_W-1:0] segments_used;

    modport source (output valid, fault, phys_base, segments_used, input ready);
    modport sink   (input valid, fault, phys_base, segments_used, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/stac_cell.sv
// One slot of the segment table: holds a segment and checks the passing
// request token against it, then hands the token to the next slot.
// Depends on stac_pkg.
`default_nettype none

module stac_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic [CNT_W-1:0]    count,
    input  logic                wr,
    input  stac_pkg::stac_entry_t wdata,
    input  logic                tin_valid,
    input  stac_pkg::stac_token_t tin,
    output logic                tout_valid,
    output stac_pkg::stac_token_t tout
);
    import stac_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    stac_entry_t       ent_reg;
    stac_token_t       tok_reg;
    stac_token_t       tok_next;
    logic              vld_reg;
    logic              active;
    logic [ADDR_W-1:0] cb;
    logic [ADDR_W-1:0] ce;
    logic [ADDR_W-1:0] pe;
    logic [ADDR_W-1:0] base_x;

    always_comb
    begin
        active   = MY_IDX < count;
        cb       = {1'b0, ent_reg.lbase};
        ce       = cb + {1'b0, ent_reg.lim};
        pe       = {1'b0, ent_reg.pbase} + {1'b0, ent_reg.lim};
        base_x   = {1'b0, tin.base};
        tok_next = tin;
        if (active)
        begin
            if ((base_x >= cb && base_x < ce) || (tin.end_addr > cb && tin.end_addr <= ce))
            begin
                tok_next.overlap = 1'b1;
            end
            if (pe > tin.top)
            begin
                tok_next.top = pe;
            end
            if (base_x >= cb && tin.end_addr <= ce)
            begin
                tok_next.hit = 1'b1;
            end
        end
    end

    // A new segment is appended at the slot whose index equals the fill count.
    always_ff @(posedge clk)
    begin
        if (wr && count == MY_IDX)
        begin
            ent_reg <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= tin_valid;
        end
    end

    assign tout_valid = vld_reg;
    assign tout       = tok_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/segment_table_allocate_check.sv
// Segment table with base/limit checking: top level.
// Depends on stac_pkg, stac_req_if, stac_rsp_if and stac_cell.
//
// Usage:
// - req channel (valid/ready) carries func, log_base and req_size. func
//   selects allocate, access check or clear; any other code faults.
// - rsp channel (valid/ready) returns one beat per request: fault,
//   phys_base (nonzero only for a successful allocate) and segments_used.
// - cfg_we/cfg_wdata write mem_available; write it only while idle.
// - A request is loaded into a head register, then walks a row of
//   SEGMENT_SLOTS cells, each holding one segment, one cell per cycle
//   unless the row stalls. The last stage does the memory-size test and
//   the append.
// - One request is in flight at a time: a new request is taken only after
//   the previous one has left the end of the cell row.
// - The response sits in an output register. If the receiver stalls, the
//   finished token waits at the end of the row until the beat is taken.
// - Reset empties the table and clears mem_available; stored segments are
//   not cleared, only the fill count.
`default_nettype none

module segment_table_allocate_check #(
    parameter int SEGMENT_SLOTS = stac_pkg::SLOTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [stac_pkg::DATA_W-1:0] cfg_wdata,
    stac_req_if.sink                    req,
    stac_rsp_if.source                  rsp
);
    import stac_pkg::*;

    localparam int CNT_W = $clog2(SEGMENT_SLOTS + 1);

    logic [DATA_W-1:0]      mem_avail_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   head_valid_reg;
    logic                   head_valid_next;
    stac_token_t            head_tok_reg;
    stac_token_t            head_tok_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_fault_reg;
    logic                   out_fault_next;
    logic [DATA_W-1:0]      out_pbase_reg;
    logic [DATA_W-1:0]      out_pbase_next;

    logic [SEGMENT_SLOTS:0] tok_v;
    stac_token_t            tok [SEGMENT_SLOTS+1];
    stac_token_t            x;
    stac_entry_t            wr_ent;
    logic                   accept;
    logic                   adv;
    logic                   fin;
    logic                   alloc_ok;
    logic                   oom;
    logic                   full;
    logic [NEED_W-1:0]      need;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;

    // The row moves unless a finished token meets a stalled output register.
    assign adv = !(tok_v[SEGMENT_SLOTS] && out_valid_reg && !rsp.ready);
    assign fin = tok_v[SEGMENT_SLOTS] && adv;

    always_comb
    begin
        head_tok_next.func     = req.func;
        head_tok_next.base     = req.log_base;
        head_tok_next.end_addr = {1'b0, req.log_base} + {1'b0, req.req_size} - ADDR_W'(1);
        head_tok_next.lim      = req.req_size - DATA_W'(1);
        head_tok_next.zero     = req.req_size == '0;
        head_tok_next.overlap  = 1'b0;
        head_tok_next.top      = '0;
        head_tok_next.hit      = 1'b0;
    end

    always_comb
    begin
        if (accept)
        begin
            head_valid_next = 1'b1;
        end
        else if (adv)
        begin
            head_valid_next = 1'b0;
        end
        else
        begin
            head_valid_next = head_valid_reg;
        end
        busy_next = accept ? 1'b1 : (fin ? 1'b0 : busy_reg);
        out_valid_next = fin ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    assign tok_v[0] = head_valid_reg;
    assign tok[0]   = head_tok_reg;

    for (genvar k = 0; k < SEGMENT_SLOTS; k++)
    begin : g_cell
        stac_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .count      (count_reg),
            .wr         (alloc_ok),
            .wdata      (wr_ent),
            .tin_valid  (tok_v[k]),
            .tin        (tok[k]),
            .tout_valid (tok_v[k+1]),
            .tout       (tok[k+1])
        );
    end

    assign x    = tok[SEGMENT_SLOTS];
    assign need = {1'b0, x.top} + {2'b00, x.lim};
    assign oom  = {2'b00, mem_avail_reg} < need;
    assign full = count_reg == CNT_W'(SEGMENT_SLOTS);

    assign wr_ent.lbase = x.base;
    assign wr_ent.lim   = x.lim;
    assign wr_ent.pbase = x.top[DATA_W-1:0];

    always_comb
    begin
        out_fault_next = 1'b1;
        out_pbase_next = '0;
        count_next     = count_reg;
        alloc_ok       = 1'b0;
        if (tok_v[SEGMENT_SLOTS])
        begin
            unique case (x.func)
                FUNC_ALLOC:
                begin
                    if (!(x.zero || x.overlap || oom || full))
                    begin
                        out_fault_next = 1'b0;
                        out_pbase_next = x.top[DATA_W-1:0];
                        count_next     = count_reg + CNT_W'(1);
                        alloc_ok       = fin;
                    end
                end
                FUNC_ACCESS:
                begin
                    out_fault_next = x.zero || !x.hit;
                end
                FUNC_CLEAR:
                begin
                    out_fault_next = 1'b0;
                    count_next     = '0;
                end
                default:
                begin
                    out_fault_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_avail_reg  <= '0;
            count_reg      <= '0;
            busy_reg       <= 1'b0;
            head_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mem_avail_reg <= cfg_wdata;
            end
            if (fin)
            begin
                count_reg <= count_next;
            end
            busy_reg       <= busy_next;
            head_valid_reg <= head_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_tok_reg <= head_tok_next;
        end
        if (fin)
        begin
            out_fault_reg <= out_fault_next;
            out_pbase_reg <= out_pbase_next;
        end
    end

    // segments_used follows the fill count, which only moves at fin.
    assign rsp.valid         = out_valid_reg;
    assign rsp.fault         = out_fault_reg;
    assign rsp.phys_base     = out_pbase_reg;
    assign rsp.segments_used = USED_W'(count_reg);

endmodule

`default_nettype wire

FILE: hw/rtl/stac_checker.sv
// Port-level checks for segment_table_allocate_check, attached by bind.
// Depends on stac_pkg and the top level's ports.
`default_nettype none

module stac_checker #(
    parameter int SEGMENT_SLOTS = stac_pkg::SLOTS_DEFAULT
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_fault,
    input logic [stac_pkg::DATA_W-1:0] rsp_phys_base,
    input logic [stac_pkg::USED_W-1:0] rsp_segments_used
);
    import stac_pkg::*;

    // A stalled response beat keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault)
            && $stable(rsp_phys_base) && $stable(rsp_segments_used))
        else $error("response changed while stalled");

    // Only one request is in flight, so the block is busy after taking one.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in flight");

    // A faulting request never reports a physical base.
    a_fault_no_base: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_fault |-> rsp_phys_base == '0)
        else $error("fault with nonzero physical base");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> int'(rsp_segments_used) <= SEGMENT_SLOTS)
        else $error("segment count beyond table size");

endmodule

bind segment_table_allocate_check stac_checker #(
    .SEGMENT_SLOTS (SEGMENT_SLOTS)
) u_stac_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_fault         (rsp.fault),
    .rsp_phys_base     (rsp.phys_base),
    .rsp_segments_used (rsp.segments_used)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for segment_table_allocate_check.
// Depends on stac_pkg, stac_req_if and stac_rsp_if; drives random stalls on both channels
// and checks every response beat against a predictor of the segment table.
module tb;
    import stac_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int DRAIN_CYCLES = SLOTS + 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 450;

    // The one request code that the package does not name.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic              fault;
        logic [DATA_W-1:0] phys_base;
        logic [USED_W-1:0] used;
    } seg_outcome_t;

    class seg_table_scoreboard;
        logic [DATA_W-1:0] mem_avail;
        logic [DATA_W-1:0] lbase [SLOTS];
        logic [DATA_W-1:0] lim   [SLOTS];
        logic [DATA_W-1:0] pbase [SLOTS];
        int unsigned       used;
        seg_outcome_t      outcome_q [$];
        int                errors;
        int                checked;
        int                placed;
        int                faults;
        int                full_rejects;

        function new();
            mem_avail    = '0;
            used         = 0;
            errors       = 0;
            checked      = 0;
            placed       = 0;
            faults       = 0;
            full_rejects = 0;
        endfunction

        function void set_mem_avail(logic [DATA_W-1:0] value);
            mem_avail = value;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Works out the response to one accepted request and updates the table.
        function void note_request(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] base,
                                   logic [DATA_W-1:0] size);
            seg_outcome_t      r;
            logic [NEED_W-1:0] base_x;
            logic [NEED_W-1:0] size_x;
            logic [NEED_W-1:0] lim_new;
            logic [NEED_W-1:0] end_new;
            logic [NEED_W-1:0] top;
            logic [NEED_W-1:0] cb;
            logic [NEED_W-1:0] ce;
            logic [NEED_W-1:0] pe;
            logic              hit;
            r       = '0;
            r.fault = 1'b1;
            base_x  = NEED_W'(base);
            size_x  = NEED_W'(size);
            case (func)
                FUNC_ALLOC: begin
                    if (size_x != '0) begin
                        lim_new = size_x - NEED_W'(1);
                        end_new = base_x + lim_new;
                        top     = '0;
                        hit     = 1'b0;
                        // The overlap test is deliberately one-sided at each end:
                        // base in [cb, ce) or end in (cb, ce].
                        for (int i = 0; i < used && !hit; i++) begin
                            cb = NEED_W'(lbase[i]);
                            ce = cb + NEED_W'(lim[i]);
                            pe = NEED_W'(pbase[i]) + NEED_W'(lim[i]);
                            if (pe > top)
                                top = pe;
                            if ((base_x >= cb && base_x < ce) ||
                                (end_new > cb && end_new <= ce))
                                hit = 1'b1;
                        end
                        if (!hit && NEED_W'(mem_avail) >= top + lim_new) begin
                            if (used < SLOTS) begin
                                lbase[used] = base;
                                lim[used]   = lim_new[DATA_W-1:0];
                                pbase[used] = top[DATA_W-1:0];
                                used++;
                                r.fault     = 1'b0;
                                r.phys_base = top[DATA_W-1:0];
                                placed++;
                            end
                            else
                                full_rejects++;
                        end
                    end
                end
                FUNC_ACCESS: begin
                    if (size_x != '0) begin
                        end_new = base_x + size_x - NEED_W'(1);
                        for (int i = 0; i < used; i++) begin
                            cb = NEED_W'(lbase[i]);
                            ce = cb + NEED_W'(lim[i]);
                            if (base_x >= cb && end_new <= ce)
                                r.fault = 1'b0;
                        end
                    end
                end
                FUNC_CLEAR: begin
                    used    = 0;
                    r.fault = 1'b0;
                end
                default: ;
            endcase
            r.used = USED_W'(used);
            if (r.fault)
                faults++;
            outcome_q.push_back(r);
        endfunction

        function void check_result(logic fault, logic [DATA_W-1:0] phys_base,
                                   logic [USED_W-1:0] seg_used);
            seg_outcome_t exp_r;
            if (outcome_q.size() == 0) begin
                $display("%0t: response beat with no request outstanding", $time);
                errors++;
                return;
            end
            exp_r = outcome_q.pop_front();
            checked++;
            if (fault !== exp_r.fault) begin
                $display("%0t: fault mismatch: expected %0d, got %0d",
                         $time, exp_r.fault, fault);
                errors++;
            end
            if (phys_base !== exp_r.phys_base) begin
                $display("%0t: phys_base mismatch: expected %06h, got %06h",
                         $time, exp_r.phys_base, phys_base);
                errors++;
            end
            if (seg_used !== exp_r.used) begin
                $display("%0t: segments_used mismatch: expected %0d, got %0d",
                         $time, exp_r.used, seg_used);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [DATA_W-1:0] cfg_wdata;
    bit                no_idle = 1'b0;
    int                idle_cycles = 0;
    int                items_sent = 0;
    int                settings_used = 0;

    seg_table_scoreboard sb = new();

    stac_req_if req_ch ();
    stac_rsp_if rsp_ch ();

    segment_table_allocate_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.func, req_ch.log_base, req_ch.req_size);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.fault, rsp_ch.phys_base, rsp_ch.segments_used);
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("segment_table_allocate_check test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: random stall before each response beat.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    // Valid stays high on return so a back-to-back request needs no toggle.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] base,
                             input logic [DATA_W-1:0] size);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= func;
        req_ch.log_base <= base;
        req_ch.req_size <= size;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mem_avail(input logic [DATA_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_mem_avail(value);
        settings_used++;
    endtask

    // One process: clear, then a run of allocations and accesses around a random logical
    // window, mixed with unused codes, zero sizes and clears. In fill mode the allocations
    // are laid end to end, up to three apart, so the table runs full.
    task automatic run_random_phase(input int count);
        logic [DATA_W-1:0] window;
        logic [DATA_W-1:0] cursor;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] size;
        logic [FUNC_W-1:0] func;
        int                kind;
        int                k;
        bit                fill;
        window = DATA_W'($urandom);
        cursor = window;
        fill   = ($urandom_range(0, 3) == 0);
        send_item(FUNC_CLEAR, DATA_W'($urandom), DATA_W'($urandom));
        repeat (count) begin
            kind = $urandom_range(0, 99);
            func = FUNC_ALLOC;
            base = DATA_W'($urandom);
            size = DATA_W'($urandom);
            if (kind < 45) begin
                size = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom_range(1, 24'hFFFFFF))
                                                   : DATA_W'($urandom_range(1, 64));
                if (fill) begin
                    base   = cursor;
                    cursor = cursor + size + DATA_W'($urandom_range(0, 3));
                end
                else
                    base = window + DATA_W'($urandom_range(0, 1023));
            end
            else if (kind < 80) begin
                func = FUNC_ACCESS;
                if (sb.used > 0) begin
                    k    = $urandom_range(0, sb.used - 1);
                    base = sb.lbase[k] + DATA_W'($urandom_range(0, 4)) - DATA_W'(2);
                    size = sb.lim[k] + DATA_W'(1) - DATA_W'($urandom_range(0, 3))
                           + DATA_W'($urandom_range(0, 2));
                end
                else begin
                    base = window + DATA_W'($urandom_range(0, 1023));
                    size = DATA_W'($urandom_range(1, 64));
                end
            end
            else if (kind < 88)
                func = FUNC_ACCESS;
            else if (kind < 93)
                func = FUNC_UNUSED;
            else if (kind < 97)
                size = '0;
            else
                func = FUNC_CLEAR;
            send_item(func, base, size);
        end
    endtask

    initial
    begin
        logic [DATA_W-1:0] mem_value;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FUNC_ALLOC;
        req_ch.log_base <= '0;
        req_ch.req_size <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Memory size still at its reset value of zero.
        send_item(FUNC_ACCESS, 24'h000000, 24'h000001);
        send_item(FUNC_ALLOC, 24'h000010, 24'h000000);
        send_item(FUNC_ACCESS, 24'h000010, 24'h000000);
        send_item(FUNC_UNUSED, 24'h000010, 24'h000001);
        send_item(FUNC_ALLOC, 24'h000100, 24'h000001);
        send_item(FUNC_ALLOC, 24'h000200, 24'h000002);
        send_item(FUNC_ACCESS, 24'h000100, 24'h000001);
        send_item(FUNC_CLEAR, 24'h000000, 24'h000000);

        write_mem_avail(24'hFFFFFF);
        send_item(FUNC_ALLOC, 24'hFFFFFF, 24'hFFFFFF);
        send_item(FUNC_ACCESS, 24'hFFFFFF, 24'hFFFFFF);
        send_item(FUNC_ACCESS, 24'hFFFFFE, 24'h000002);
        send_item(FUNC_ALLOC, 24'h000000, 24'hFFFFFF);
        send_item(FUNC_CLEAR, 24'hFFFFFF, 24'hFFFFFF);
        // Edges of the one-sided overlap test, and a segment that encloses
        // an existing one without being caught.
        send_item(FUNC_ALLOC, 24'h001000, 24'h000100);
        send_item(FUNC_ALLOC, 24'h0010FF, 24'h000001);
        send_item(FUNC_ALLOC, 24'h001080, 24'h000010);
        send_item(FUNC_ALLOC, 24'h000F00, 24'h000101);
        send_item(FUNC_ALLOC, 24'h000800, 24'h002000);
        send_item(FUNC_ACCESS, 24'h000800, 24'h002000);
        send_item(FUNC_ACCESS, 24'h0027FF, 24'h000002);
        send_item(FUNC_CLEAR, 24'h000000, 24'h000000);

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 4))
                0:       mem_value = '0;
                1:       mem_value = 24'hFFFFFF;
                2:       mem_value = DATA_W'($urandom_range(0, 255));
                3:       mem_value = DATA_W'($urandom_range(256, 4095));
                default: mem_value = DATA_W'($urandom);
            endcase
            write_mem_avail(mem_value);
            no_idle = ($urandom_range(0, 3) == 0);
            run_random_phase($urandom_range(10, 40));
        end
        no_idle = 1'b0;
        settle();

        $display("Covered %0d requests over %0d memory sizes: %0d segments placed, %0d faults",
                 items_sent, settings_used, sb.placed, sb.faults);
        $display("%0d of them table-full rejections; %0d responses checked, %0d mismatches",
                 sb.full_rejects, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("segment_table_allocate_check test passed");
        else
            $display("segment_table_allocate_check test failed");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/stac_pkg.sv
hw/rtl/stac_req_if.sv
hw/rtl/stac_rsp_if.sv
hw/rtl/stac_cell.sv
hw/rtl/segment_table_allocate_check.sv
hw/rtl/stac_checker.sv
tb/sv/tb.sv
